// File: hw/rtl/bra_pkg.sv
// Shared types and constants for the best rational approximation block.
// Holds the controller/datapath command and status structs and the state enum.
// No dependencies.
package bra_pkg;

  localparam int unsigned IN_W      = 32;              // whole/fraction port fields
  localparam int unsigned DEN_W     = 32;              // convergent terms, limit register
  localparam int unsigned OUT_W     = 33;              // signed result fields
  localparam int unsigned ACC_W     = DEN_W + 2;       // shift-add product accumulators
  localparam int unsigned S_TDATA_W = 2 * IN_W;
  localparam int unsigned M_TDATA_W = 104;
  localparam int unsigned M_PAD_W   = M_TDATA_W - 2 * OUT_W - DEN_W;

  localparam logic [DEN_W-1:0] MAX_DEN_RESET = 32'd1000000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_UPDATE,
    ST_FINISH
  } bra_state_t;

  typedef struct packed {
    logic start;     // load a new beat and set up the first Euclid step
    logic div_step;  // one restoring-division iteration
    logic update;    // close a Euclid step: limit test and convergent update
    logic load_out;  // copy the result into the output register
  } bra_cmd_t;

  typedef struct packed {
    logic q_zero;    // divisor is zero: expansion finished
    logic div_last;  // the current iteration produces the last quotient bit
    logic stop;      // limit exceeded or remainder zero
  } bra_sts_t;

endpackage

// File: hw/rtl/bra_datapath.sv
// Datapath: limit register, bit-serial Euclid divider with shift-add products,
// convergent registers and the output register.
// Depends on bra_pkg.
module bra_datapath import bra_pkg::*; #(
  parameter int unsigned FRAC_W  = 32,
  parameter int unsigned WHOLE_W = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  bra_cmd_t                cmd,
  output bra_sts_t                sts,
  input  logic                    cfg_we,
  input  logic [DEN_W-1:0]        cfg_wdata,
  input  logic                    is_negative,
  input  logic [IN_W-1:0]         whole_magnitude,
  input  logic [IN_W-1:0]         fraction_bits,
  output logic signed [OUT_W-1:0] whole_part,
  output logic signed [OUT_W-1:0] numerator_out,
  output logic [DEN_W-1:0]        denominator_out
);

  localparam int unsigned CNT_W      = $clog2(FRAC_W + 2);
  localparam int unsigned WHOLE_USED = (WHOLE_W < IN_W) ? WHOLE_W : IN_W;

  logic [DEN_W-1:0]  max_den;
  logic [DEN_W-1:0]  limit;
  logic [ACC_W-1:0]  limit_ext;

  logic              neg;
  logic [IN_W-1:0]   whole;
  logic [IN_W-1:0]   whole_mask;

  logic [FRAC_W:0]   dvd;
  logic [FRAC_W-1:0] q;
  logic [FRAC_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic [ACC_W-1:0]  acc_n;
  logic [ACC_W-1:0]  acc_d;
  logic              over;

  logic [DEN_W-1:0]  n_cur;
  logic [DEN_W-1:0]  n_prev;
  logic [DEN_W-1:0]  d_cur;
  logic [DEN_W-1:0]  d_prev;

  logic [FRAC_W:0]   trial;
  logic              ge;
  logic [FRAC_W-1:0] rem_next;
  logic [ACC_W-1:0]  acc_n_next;
  logic [ACC_W-1:0]  acc_d_next;
  logic              over_next;
  logic [ACC_W-1:0]  sum_n;
  logic [ACC_W-1:0]  sum_d;
  logic              brk;

  logic [OUT_W-1:0]  whole_ext;
  logic [OUT_W-1:0]  num_ext;

  // A zero limit acts as one.
  assign limit     = (max_den == '0) ? DEN_W'(1) : max_den;
  assign limit_ext = ACC_W'(limit);

  assign whole_mask = IN_W'((64'd1 << WHOLE_USED) - 64'd1);

  // Restoring division, one quotient bit per cycle, MSB first; the quotient
  // bit feeds the products a*n_cur and a*d_cur straight away.
  assign trial    = {rem, dvd[FRAC_W]};
  assign ge       = (trial >= {1'b0, q});
  assign rem_next = ge ? FRAC_W'(trial - {1'b0, q}) : trial[FRAC_W-1:0];

  assign acc_n_next = {acc_n[ACC_W-2:0], 1'b0} + (ge ? ACC_W'(n_cur) : ACC_W'(0));
  assign acc_d_next = {acc_d[ACC_W-2:0], 1'b0} + (ge ? ACC_W'(d_cur) : ACC_W'(0));
  // The partial product only grows, so once past the limit it stays past it.
  assign over_next  = over | (acc_d_next > limit_ext);

  assign sum_n = acc_n + ACC_W'(n_prev);
  assign sum_d = acc_d + ACC_W'(d_prev);
  assign brk   = over | (sum_d > limit_ext);

  assign sts.q_zero   = (q == '0);
  assign sts.div_last = (cnt == CNT_W'(FRAC_W));
  assign sts.stop     = brk | (rem == '0);

  assign whole_ext = {1'b0, whole};
  assign num_ext   = {1'b0, n_cur};

  always_ff @(posedge clk) begin
    if (rst) begin
      max_den <= MAX_DEN_RESET;
    end else if (cfg_we) begin
      max_den <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      neg    <= is_negative;
      whole  <= whole_magnitude & whole_mask;
      // First Euclid step folded in: a0 = 0, remainder is the fraction itself.
      dvd    <= {1'b1, {FRAC_W{1'b0}}};
      q      <= FRAC_W'(fraction_bits);
      n_cur  <= '0;
      n_prev <= DEN_W'(1);
      d_cur  <= DEN_W'(1);
      d_prev <= '0;
      rem    <= '0;
      cnt    <= '0;
      acc_n  <= '0;
      acc_d  <= '0;
      over   <= 1'b0;
    end else if (cmd.div_step) begin
      dvd   <= {dvd[FRAC_W-1:0], 1'b0};
      rem   <= rem_next;
      cnt   <= cnt + CNT_W'(1);
      acc_n <= acc_n_next;
      acc_d <= acc_d_next;
      over  <= over_next;
    end else if (cmd.update && !brk) begin
      n_prev <= n_cur;
      n_cur  <= sum_n[DEN_W-1:0];
      d_prev <= d_cur;
      d_cur  <= sum_d[DEN_W-1:0];
      dvd    <= {1'b0, q};
      q      <= rem;
      rem    <= '0;
      cnt    <= '0;
      acc_n  <= '0;
      acc_d  <= '0;
      over   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      whole_part      <= neg ? OUT_W'(0) - whole_ext : whole_ext;
      numerator_out   <= neg ? OUT_W'(0) - num_ext : num_ext;
      denominator_out <= d_cur;
    end
  end

`ifndef SYNTHESIS
  a_no_div_by_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !sts.q_zero)
    else $error("division step issued with a zero divisor");

  a_full_quotient: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> cnt == CNT_W'(FRAC_W + 1))
    else $error("Euclid step closed before all quotient bits were produced");

  a_convergent_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.update && !brk |=> (d_prev <= d_cur) && (d_cur <= limit) && (n_cur <= d_cur))
    else $error("convergent outside its bounds after update");
`endif

endmodule

// File: hw/rtl/bra_ctrl.sv
// Controller: sequences start, division iterations, Euclid updates and the
// hand-off to the output register; owns the output valid flag.
// Depends on bra_pkg.
module bra_ctrl import bra_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  bra_sts_t sts,
  output bra_cmd_t cmd
);

  bra_state_t state;
  bra_state_t state_next;
  logic       out_valid;
  logic       out_valid_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (sts.q_zero) begin
          state_next = ST_FINISH;
        end else if (sts.div_last) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = sts.stop ? ST_FINISH : ST_DIVIDE;
      end
      ST_FINISH: begin
        if (!out_valid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = (state == ST_IDLE);
    cmd.start    = (state == ST_IDLE) && s_tvalid;
    cmd.div_step = (state == ST_DIVIDE) && !sts.q_zero;
    cmd.update   = (state == ST_UPDATE);
    // Hand over only when the output register is free or being emptied.
    cmd.load_out = (state == ST_FINISH) && (!out_valid || m_tready);
  end

  assign out_valid_next = cmd.load_out ? 1'b1 : (m_tready ? 1'b0 : out_valid);
  assign m_tvalid       = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !out_valid || m_tready)
    else $error("output register overwritten while its beat is pending");

  a_start_divides: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_DIVIDE)
    else $error("accepted beat did not start the divider");

  a_finish_waits: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && !cmd.load_out |=> state == ST_FINISH && m_tvalid)
    else $error("finished result left without reaching the output register");
`endif

endmodule

// File: hw/rtl/best_rational_approximation.sv
// Best rational approximation of a signed fixed-point value by continued fractions.
// One item at a time: a new beat is taken only in the idle state, once the bit-serial
// divider and the update of each Euclid step are done; a zero fraction skips the divider.
// The next beat is taken while a finished result waits in the output register.
// Reset (rst, synchronous): controller idle, output empty, max_denominator = 1000000.
module best_rational_approximation import bra_pkg::*; #(
  parameter int unsigned FRACTION_WIDTH = 32,
  parameter int unsigned WHOLE_WIDTH    = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [DEN_W-1:0]     cfg_wdata,   // max_denominator
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,     // whole_magnitude[31:0], fraction_bits[63:32]
  input  logic                 s_tuser,     // is_negative
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata      // whole_part[32:0], numerator_out[65:33],
                                            // denominator_out[97:66], zero[103:98]
);

  bra_cmd_t                cmd;
  bra_sts_t                sts;
  logic signed [OUT_W-1:0] whole_part;
  logic signed [OUT_W-1:0] numerator_out;
  logic [DEN_W-1:0]        denominator_out;

  bra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bra_datapath #(
    .FRAC_W  (FRACTION_WIDTH),
    .WHOLE_W (WHOLE_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .is_negative     (s_tuser),
    .whole_magnitude (s_tdata[IN_W-1:0]),
    .fraction_bits   (s_tdata[2*IN_W-1:IN_W]),
    .whole_part      (whole_part),
    .numerator_out   (numerator_out),
    .denominator_out (denominator_out)
  );

  assign m_tdata = {{M_PAD_W{1'b0}}, denominator_out, numerator_out, whole_part};

endmodule
